### hw/rtl/cte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types, constants and calendar tables for the civil time to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned OffsetW = 18;
  localparam int unsigned EpochW  = 39;
  localparam int unsigned StatusW = 2;

  // day count since 1970-01-01 stays below 2^22 for years up to 9999
  localparam int unsigned DaysW   = 22;
  // seconds within one day
  localparam int unsigned SodW    = 17;
  // quotient of (year - 1) / 100
  localparam int unsigned CentW   = 8;

  localparam logic [YearW-1:0] YEAR_MIN = 14'd1970;
  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;

  // leaps_through(1969) = 1969/4 - 1969/100 + 1969/400
  localparam logic [DaysW-1:0] LEAPS_BEFORE_MIN = 22'd477;

  localparam logic [SodW-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [SodW-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [EpochW-1:0] SECS_PER_DAY = 39'd86400;

  // last second of 9999-12-31 UTC
  localparam logic signed [EpochW:0] LAST_INSTANT = 40'sd253402300799;

  // n / 100 == (n * 5243) >> 19 for every 14-bit n
  localparam int unsigned RecipShift = 19;
  localparam logic [YearW+RecipShift-7:0] RECIP_100 = 27'd5243;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIELD = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // first stage result: fields plus century quotient of (year - 1)
  typedef struct packed {
    logic [YearW-1:0]          year;
    logic [MonthW-1:0]         month;
    logic [DayW-1:0]           day;
    logic [HourW-1:0]          hour;
    logic [MinuteW-1:0]        minute;
    logic [SecondW-1:0]        second;
    logic signed [OffsetW-1:0] offset;
    logic [CentW-1:0]          cent;
    logic                      fields_ok;
  } split_t;

  // second stage result: day count and seconds within the day
  typedef struct packed {
    logic                      ok;
    logic [DaysW-1:0]          days;
    logic [SodW-1:0]           sod;
    logic signed [OffsetW-1:0] offset;
  } count_t;

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] mi);
    logic [8:0] d;
    unique case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mi);
    logic [DayW-1:0] l;
    unique case (mi)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: l = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   l = 5'd30;
      4'd1:                                      l = 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

### hw/rtl/civil_time_to_epoch_seconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds
// Converts a Gregorian date and time with a UTC offset into Unix seconds.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid with the date, time and offset fields; a
//   transaction completes when in_valid is high and in_stall is low.
//   result channel: out_valid with out_epoch_seconds and out_status; the
//   receiver holds out_stall high to keep the result in place.
//   each input transaction gives exactly one result, in order.
// Timing:
//   three register stages (century split, day count, seconds and range
//   check); throughput is one transaction per cycle unless out_stall
//   backs the pipeline up; the constant multiplies in the day count and
//   seconds stages set the cycle time.
// Reset:
//   synchronous active-low rst_n empties all stages; no result is pending.
// Backpressure:
//   a stalled result holds its value; stages behind it keep filling until
//   each holds a transaction, then in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cte_pkg::YearW-1:0]         in_year,
  input  logic [cte_pkg::MonthW-1:0]        in_month,
  input  logic [cte_pkg::DayW-1:0]          in_day,
  input  logic [cte_pkg::HourW-1:0]         in_hour,
  input  logic [cte_pkg::MinuteW-1:0]       in_minute,
  input  logic [cte_pkg::SecondW-1:0]       in_second,
  input  logic signed [cte_pkg::OffsetW-1:0] in_offset_seconds,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cte_pkg::EpochW-1:0] out_epoch_seconds,
  output logic [cte_pkg::StatusW-1:0]       out_status
);
  import cte_pkg::*;

  logic   split_valid;
  logic   split_stall;
  split_t split_data;
  logic   count_valid;
  logic   count_stall;
  count_t count_data;

  cte_year_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_valid),
    .stall_o  (in_stall),
    .year_i   (in_year),
    .month_i  (in_month),
    .day_i    (in_day),
    .hour_i   (in_hour),
    .minute_i (in_minute),
    .second_i (in_second),
    .offset_i (in_offset_seconds),
    .valid_o  (split_valid),
    .stall_i  (split_stall),
    .data_o   (split_data)
  );

  cte_day_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (split_valid),
    .stall_o (split_stall),
    .data_i  (split_data),
    .valid_o (count_valid),
    .stall_i (count_stall),
    .data_o  (count_data)
  );

  cte_seconds u_secs (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (count_valid),
    .stall_o  (count_stall),
    .data_i   (count_data),
    .valid_o  (out_valid),
    .stall_i  (out_stall),
    .epoch_o  (out_epoch_seconds),
    .status_o (out_status)
  );

endmodule

### hw/rtl/cte_year_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_year_split
// First stage: range checks on the plain fields and the century quotient
// of (year - 1) by reciprocal multiplication.
// ----------------------------------------------------------------------------
module cte_year_split (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [cte_pkg::YearW-1:0]          year_i,
  input  logic [cte_pkg::MonthW-1:0]         month_i,
  input  logic [cte_pkg::DayW-1:0]           day_i,
  input  logic [cte_pkg::HourW-1:0]          hour_i,
  input  logic [cte_pkg::MinuteW-1:0]        minute_i,
  input  logic [cte_pkg::SecondW-1:0]        second_i,
  input  logic signed [cte_pkg::OffsetW-1:0] offset_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output cte_pkg::split_t                    data_o
);
  import cte_pkg::*;

  logic                          valid_r;
  logic                          valid_nxt;
  logic                          advance;
  split_t                        data_r;
  split_t                        data_nxt;
  logic [YearW-1:0]              year_m1;
  logic [YearW+RecipShift-7:0]   prod;

  assign advance = !valid_r || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    year_m1 = year_i - 14'd1;
    prod    = {13'd0, year_m1} * RECIP_100;

    data_nxt.year      = year_i;
    data_nxt.month     = month_i;
    data_nxt.day       = day_i;
    data_nxt.hour      = hour_i;
    data_nxt.minute    = minute_i;
    data_nxt.second    = second_i;
    data_nxt.offset    = offset_i;
    data_nxt.cent      = prod[RecipShift+CentW-1:RecipShift];
    data_nxt.fields_ok = (year_i >= YEAR_MIN) && (year_i <= YEAR_MAX) &&
                         (month_i >= 4'd1) && (month_i <= 4'd12) &&
                         (day_i != 5'd0) && (hour_i < 5'd24) &&
                         (minute_i < 6'd60) && (second_i < 6'd60);
  end

  assign valid_nxt = advance ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### hw/rtl/cte_day_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_day_count
// Second stage: leap year test, day-of-month check, days since 1970-01-01
// and seconds within the day.
// ----------------------------------------------------------------------------
module cte_day_count (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            stall_o,
  input  cte_pkg::split_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output cte_pkg::count_t data_o
);
  import cte_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic               advance;
  count_t             data_r;
  count_t             data_nxt;
  logic [YearW-1:0]   year_m1;
  logic [YearW-1:0]   cent_x100;
  logic [6:0]         rem100;
  logic [CentW-1:0]   cent_p1;
  logic               leap;
  logic [MonthW-1:0]  mi;
  logic [DayW-1:0]    mlen;
  logic [YearW-1:0]   yr_off;
  logic [DaysW-1:0]   days_base;

  assign advance = !valid_r || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    year_m1   = data_i.year - 14'd1;
    cent_x100 = 14'({6'd0, data_i.cent} * 14'd100);
    rem100    = 7'(year_m1 - cent_x100);
    cent_p1   = data_i.cent + 8'd1;
    // year divisible by 100 exactly when (year - 1) leaves 99
    leap = (data_i.year[1:0] == 2'd0) &&
           ((rem100 != 7'd99) || (cent_p1[1:0] == 2'd0));

    mi   = data_i.month - 4'd1;
    mlen = month_len(mi) + {4'd0, (mi == 4'd1) && leap};

    yr_off    = data_i.year - YEAR_MIN;
    days_base = 22'({8'd0, yr_off} * 22'd365);

    data_nxt.ok   = data_i.fields_ok && (data_i.day <= mlen);
    data_nxt.days = days_base
                  + {10'd0, year_m1[YearW-1:2]}
                  - {14'd0, data_i.cent}
                  + {16'd0, data_i.cent[CentW-1:2]}
                  - LEAPS_BEFORE_MIN
                  + {13'd0, days_before(mi)}
                  + {21'd0, (mi > 4'd1) && leap}
                  + {17'd0, data_i.day}
                  - 22'd1;
    data_nxt.sod  = 17'({12'd0, data_i.hour} * SECS_PER_HOUR)
                  + 17'({11'd0, data_i.minute} * SECS_PER_MIN)
                  + {11'd0, data_i.second};
    data_nxt.offset = data_i.offset;
  end

  assign valid_nxt = advance ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### hw/rtl/cte_seconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_seconds
// Result stage: days times seconds per day, plus time of day, minus the
// offset, with the range check and the status code.
// ----------------------------------------------------------------------------
module cte_seconds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  cte_pkg::count_t                   data_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [cte_pkg::EpochW-1:0] epoch_o,
  output logic [cte_pkg::StatusW-1:0]       status_o
);
  import cte_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic                      advance;
  logic signed [EpochW-1:0]  epoch_r;
  logic signed [EpochW-1:0]  epoch_nxt;
  status_t                   status_r;
  status_t                   status_nxt;
  logic [EpochW-1:0]         day_secs;
  logic signed [EpochW:0]    instant;

  assign advance = !valid_r || !stall_i;
  assign stall_o = !advance;

  always_comb begin
    day_secs = {17'd0, data_i.days} * SECS_PER_DAY;
    instant  = $signed({1'b0, day_secs})
             + $signed({23'd0, data_i.sod})
             - $signed({{(EpochW+1-OffsetW){data_i.offset[OffsetW-1]}}, data_i.offset});

    priority if (!data_i.ok) begin
      status_nxt = ST_BAD_FIELD;
      epoch_nxt  = '0;
    end else if (instant[EpochW] || (instant > LAST_INSTANT)) begin
      status_nxt = ST_RANGE;
      epoch_nxt  = instant[EpochW-1:0];
    end else begin
      status_nxt = ST_OK;
      epoch_nxt  = instant[EpochW-1:0];
    end
  end

  assign valid_nxt = advance ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_i) begin
      epoch_r  <= epoch_nxt;
      status_r <= status_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign epoch_o  = epoch_r;
  assign status_o = status_r;

endmodule

### hw/rtl/cte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module cte_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [cte_pkg::EpochW-1:0] out_epoch_seconds,
  input logic [cte_pkg::StatusW-1:0]       out_status
);
  import cte_pkg::*;

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_epoch_seconds) &&
                               $stable(out_status))
    else $error("result changed while stalled");

  // rejected fields give a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_FIELD) |-> (out_epoch_seconds == '0))
    else $error("nonzero result with bad field status");

  // a good result is never before the epoch
  a_ok_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> !out_epoch_seconds[EpochW-1])
    else $error("negative result with ok status");

  // the input side only stalls when the result side is stalled
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled without output backpressure");

endmodule

bind civil_time_to_epoch_seconds cte_checker u_cte_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_epoch_seconds (out_epoch_seconds),
  .out_status        (out_status)
);

### test/cte_stamp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_stamp_checker
// Watches both channels of the civil time converter. For every accepted
// input transaction it computes the Unix seconds and the status, queues
// them, and compares each accepted result with the oldest entry.
// ----------------------------------------------------------------------------
module cte_stamp_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [cte_pkg::YearW-1:0]          in_year,
  input  logic [cte_pkg::MonthW-1:0]         in_month,
  input  logic [cte_pkg::DayW-1:0]           in_day,
  input  logic [cte_pkg::HourW-1:0]          in_hour,
  input  logic [cte_pkg::MinuteW-1:0]        in_minute,
  input  logic [cte_pkg::SecondW-1:0]        in_second,
  input  logic signed [cte_pkg::OffsetW-1:0] in_offset_seconds,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [cte_pkg::EpochW-1:0]  out_epoch_seconds,
  input  logic [cte_pkg::StatusW-1:0]        out_status,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 ok_count,
  output int                                 bad_field_count,
  output int                                 range_count
);
  import cte_pkg::*;

  localparam longint DAY_SECONDS  = 86400;
  localparam int     EPOCH_YEAR   = 1970;

  localparam int unsigned DAYS_AHEAD[12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int unsigned DAYS_IN[12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic signed [EpochW-1:0] epoch;
    status_t                  status;
  } stamp_t;

  stamp_t expected_stamps[$];

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // leap days in years 1..y
  function automatic int unsigned leap_days_upto(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic stamp_t civil_to_unix(
    input logic [YearW-1:0]          y,
    input logic [MonthW-1:0]         mo,
    input logic [DayW-1:0]           d,
    input logic [HourW-1:0]          h,
    input logic [MinuteW-1:0]        mi,
    input logic [SecondW-1:0]        s,
    input logic signed [OffsetW-1:0] off
  );
    stamp_t      r;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    longint      ofs;
    longint      days;
    longint      secs;
    bit          fields_ok;
    yr  = y;
    mon = mo;
    ofs = off;
    fields_ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (mon >= 1) && (mon <= 12);
    if (fields_ok) begin
      mlen = DAYS_IN[mon-1] + ((mon == 2 && is_leap_year(yr)) ? 1 : 0);
      fields_ok = (d >= 1) && (d <= mlen) && (h < 24) && (mi < 60) && (s < 60);
    end
    if (!fields_ok) begin
      r.epoch  = '0;
      r.status = ST_BAD_FIELD;
      return r;
    end
    days = longint'(yr - EPOCH_YEAR) * 365
         + longint'(leap_days_upto(yr - 1)) - longint'(leap_days_upto(EPOCH_YEAR - 1))
         + longint'(DAYS_AHEAD[mon-1]) + ((mon > 2 && is_leap_year(yr)) ? 1 : 0)
         + longint'(d) - 1;
    secs = days * DAY_SECONDS + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s) - ofs;
    r.epoch = secs[EpochW-1:0];
    if (secs < 0 || secs > LAST_INSTANT) r.status = ST_RANGE;
    else r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    stamp_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      expected_stamps.delete();
      fail_count      <= 0;
      pending_count   <= 0;
      ok_count        <= 0;
      bad_field_count <= 0;
      range_count     <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_stamps.size() == 0) begin
          $error("result transaction with nothing expected: epoch_seconds %0d status %0d",
                 out_epoch_seconds, out_status);
          errs++;
        end else begin
          want = expected_stamps.pop_front();
          if (out_epoch_seconds !== want.epoch) begin
            $error("epoch_seconds mismatch: expected %0d, actual %0d",
                   want.epoch, out_epoch_seconds);
            errs++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          case (want.status)
            ST_OK:        ok_count <= ok_count + 1;
            ST_BAD_FIELD: bad_field_count <= bad_field_count + 1;
            default:      range_count <= range_count + 1;
          endcase
        end
      end
      if (in_valid && !in_stall)
        expected_stamps.push_back(civil_to_unix(in_year, in_month, in_day, in_hour,
                                                in_minute, in_second, in_offset_seconds));
      fail_count    <= fail_count + errs;
      pending_count <= expected_stamps.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the civil time to epoch seconds converter with directed edge dates
// and random timestamps under random gaps and result stalls, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import cte_pkg::*;

  localparam int RANDOM_STAMPS = 1300;
  localparam int HOLD_CYCLES   = 80;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 12;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [YearW-1:0]           in_year = '0;
  logic [MonthW-1:0]          in_month = '0;
  logic [DayW-1:0]            in_day = '0;
  logic [HourW-1:0]           in_hour = '0;
  logic [MinuteW-1:0]         in_minute = '0;
  logic [SecondW-1:0]         in_second = '0;
  logic signed [OffsetW-1:0]  in_offset_seconds = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [EpochW-1:0]   out_epoch_seconds;
  logic [StatusW-1:0]         out_status;

  int fail_count;
  int pending_count;
  int ok_count;
  int bad_field_count;
  int range_count;

  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent = 0;

  civil_time_to_epoch_seconds dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .in_offset_seconds (in_offset_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status)
  );

  cte_stamp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .in_offset_seconds (in_offset_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .ok_count          (ok_count),
    .bad_field_count   (bad_field_count),
    .range_count       (range_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HOLD_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= snk_gaps && ($urandom_range(99) < 33);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer_stamp(input int y, input int mo, input int d, input int h,
                             input int mi, input int s, input int off);
    while (src_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_year           <= YearW'(y);
    in_month          <= MonthW'(mo);
    in_day            <= DayW'(d);
    in_hour           <= HourW'(h);
    in_minute         <= MinuteW'(mi);
    in_second         <= SecondW'(s);
    in_offset_seconds <= OffsetW'(off);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic offer_random_stamp();
    int pick;
    int off;
    pick = $urandom_range(99);
    off  = $urandom_range(172680) - 86340;
    if (pick < 60) begin
      // well-formed date and time
      offer_stamp($urandom_range(9999, 1970), $urandom_range(12, 1), $urandom_range(28, 1),
                  $urandom_range(23), $urandom_range(59), $urandom_range(59), off);
    end else if (pick < 70) begin
      // month ends, some of them past the real length
      offer_stamp($urandom_range(9999, 1970), $urandom_range(12, 1), $urandom_range(31, 29),
                  $urandom_range(23), $urandom_range(59), $urandom_range(59), off);
    end else if (pick < 76) begin
      offer_stamp($urandom_range(9999, 1970), 2, 29, $urandom_range(23), $urandom_range(59),
                  $urandom_range(59), off);
    end else if (pick < 82) begin
      // first day: positive offsets can land before the epoch
      offer_stamp(1970, 1, 1, $urandom_range(23), $urandom_range(59), $urandom_range(59),
                  $urandom_range(86340));
    end else if (pick < 88) begin
      // last day: negative offsets can land past year 9999
      offer_stamp(9999, 12, 31, $urandom_range(23), $urandom_range(59), $urandom_range(59),
                  -$urandom_range(86340));
    end else if (pick < 97) begin
      offer_stamp($urandom_range(9999), $urandom_range(15), $urandom_range(31),
                  $urandom_range(31), $urandom_range(63), $urandom_range(63), off);
    end else begin
      // offset outside the usual range, any 18-bit value
      offer_stamp($urandom_range(9999, 1970), $urandom_range(12, 1), $urandom_range(28, 1),
                  $urandom_range(23), $urandom_range(59), $urandom_range(59),
                  $urandom_range(262143) - 131072);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_stamp(1970, 1, 1, 0, 0, 0, 0);
    offer_stamp(1970, 1, 1, 0, 0, 0, 1);
    offer_stamp(1970, 1, 1, 0, 0, 0, -86340);
    offer_stamp(9999, 12, 31, 23, 59, 59, 0);
    offer_stamp(9999, 12, 31, 23, 59, 59, -1);
    offer_stamp(9999, 12, 31, 23, 59, 59, 86340);
    offer_stamp(1969, 12, 31, 23, 59, 59, 0);
    offer_stamp(0, 1, 1, 0, 0, 0, 0);
    offer_stamp(2000, 2, 29, 12, 0, 0, 3600);
    offer_stamp(2100, 2, 29, 0, 0, 0, 0);
    offer_stamp(2024, 2, 29, 6, 30, 15, -19800);
    offer_stamp(2023, 2, 29, 6, 30, 15, 0);
    offer_stamp(2024, 3, 1, 0, 0, 0, 0);
    offer_stamp(2024, 0, 10, 0, 0, 0, 0);
    offer_stamp(2024, 13, 1, 0, 0, 0, 0);
    offer_stamp(2024, 15, 31, 31, 63, 63, 0);
    offer_stamp(2024, 4, 31, 0, 0, 0, 0);
    offer_stamp(2024, 1, 31, 23, 59, 59, 0);
    offer_stamp(2024, 1, 0, 0, 0, 0, 0);
    offer_stamp(2024, 6, 15, 24, 0, 0, 0);
    offer_stamp(2024, 6, 15, 31, 0, 0, 0);
    offer_stamp(2024, 6, 15, 0, 60, 0, 0);
    offer_stamp(2024, 6, 15, 0, 0, 60, 0);
    offer_stamp(2024, 6, 15, 12, 0, 0, -131072);
    offer_stamp(2024, 6, 15, 12, 0, 0, 131071);

    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      // back-to-back stretch with no gaps on either side
      src_gaps = !(i >= 300 && i < 550);
      snk_gaps <= !(i >= 300 && i < 550);
      if (i == 800) hold_req_cnt <= hold_req_cnt + 1;
      // keep offering while the receiver holds off so the pipe fills
      if (i >= 800 && i < 900) src_gaps = 1'b0;
      offer_random_stamp();
    end
    in_valid <= 1'b0;

    // let the count of the last transaction settle first
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d timestamps sent: %0d converted, %0d rejected fields, %0d out of range",
             sent, ok_count, bad_field_count, range_count);
    $display("covered calendar edges, leap days, offset extremes and a long result hold-off");
    if (fail_count + pending_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
